@@ src/irwf_pkg.sv @@
package irwf_pkg;

	localparam int SAMPLE_W = 12;
	localparam int DIST_W   = 15;
	localparam int DUTY_W   = 16;
	localparam int PROD_W   = 28;
	localparam int NEAR_W   = 7;

	localparam logic [DIST_W-1:0] DIST_NUM   = 15'd27500;
	localparam logic [DIST_W-1:0] NEAR_LIMIT = 15'd20;
	localparam logic [DIST_W-1:0] FAR_LIMIT  = 15'd80;
	localparam logic [DUTY_W-1:0] DUTY_FULL  = 16'd40000;
	localparam logic [DUTY_W-1:0] FAR_DUTY   = 16'd20000;

	localparam logic [1:0] LED_FORWARD  = 2'd0;
	localparam logic [1:0] LED_TOWARD_B = 2'd1;
	localparam logic [1:0] LED_TOWARD_A = 2'd2;
	localparam logic [1:0] LED_STOPPED  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_A,
		ST_DIV_B,
		ST_STEER
	} state_t;

	typedef struct packed {
		logic                start;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIST_W-1:0] quot;
	} div_rsp_t;

	// d * 500 = d * 512 - d * 8 - d * 4
	function automatic logic [DUTY_W-1:0] times_500(input logic [NEAR_W-1:0] d);
		return {d, 9'b0} - {6'b0, d, 3'b0} - {7'b0, d, 2'b0};
	endfunction

	function automatic logic [DUTY_W-1:0] times_1000(input logic [NEAR_W-1:0] d);
		logic [DUTY_W-1:0] half;
		half = times_500(d);
		return {half[DUTY_W-2:0], 1'b0};
	endfunction

endpackage

@@ src/irwf_in_if.sv @@
interface irwf_in_if;
	import irwf_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_a;
	logic [SAMPLE_W-1:0] sample_b;
	logic [SAMPLE_W-1:0] pot_sample;

	modport source (output valid, output sample_a, output sample_b, output pot_sample,
		input ready);
	modport sink (input valid, input sample_a, input sample_b, input pot_sample,
		output ready);

endinterface

@@ src/irwf_out_if.sv @@
interface irwf_out_if;
	import irwf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_a;
	logic [DUTY_W-1:0] duty_b;
	logic [DIST_W-1:0] dist_a;
	logic [DIST_W-1:0] dist_b;
	logic [1:0]        led_code;

	modport source (output valid, output duty_a, output duty_b, output dist_a,
		output dist_b, output led_code, input ready);
	modport sink (input valid, input duty_a, input duty_b, input dist_a,
		input dist_b, input led_code, output ready);

endinterface

@@ src/irwf_div.sv @@
module irwf_div
	import irwf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic [3:0]          idx_q;
	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W-1:0] dvs_q;
	logic [DIST_W-1:0]   quot_q;

	logic [SAMPLE_W:0]   trial;
	logic [SAMPLE_W:0]   diff;
	logic                ge;

	// one quotient bit per cycle, dividend bits taken MSB first
	always_comb begin
		trial = {rem_q, DIST_NUM[idx_q]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			idx_q  <= 4'(DIST_W - 1);
		end else if (busy_q) begin
			if (idx_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				idx_q <= idx_q - 4'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			dvs_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			quot_q <= {quot_q[DIST_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ src/irwf_mul.sv @@
module irwf_mul
	import irwf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SAMPLE_W-1:0] pot,
	output logic                busy,
	output logic [DUTY_W-1:0]   base
);

	logic                busy_q;
	logic [3:0]          cnt_q;
	logic [SAMPLE_W-1:0] pot_q;
	logic [PROD_W-1:0]   acc_q;
	logic [PROD_W-1:0]   addend;

	// shift-add, pot bits MSB first
	assign addend = pot_q[SAMPLE_W-1] ? {{(PROD_W-DUTY_W){1'b0}}, DUTY_FULL} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'(SAMPLE_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pot_q <= pot;
			acc_q <= '0;
		end else if (busy_q) begin
			pot_q <= {pot_q[SAMPLE_W-2:0], 1'b0};
			acc_q <= {acc_q[PROD_W-2:0], 1'b0} + addend;
		end
	end

	assign busy = busy_q;
	// divide by 4096: drop the low twelve bits
	assign base = acc_q[PROD_W-1 -: DUTY_W];

endmodule

@@ src/ir_wall_follow_duty_steer_unit.sv @@
// channel  | modport | transfer when       | payload
// samples  | sink    | valid && ready     | sample_a, sample_b, pot_sample
// result   | source  | valid && ready     | duty_a, duty_b, dist_a, dist_b, led_code
//
// Each item runs both distances in turn on the single bit-serial divider (A then B,
// 15 quotient bits each, then a done pulse), then the steer state; no new item is
// accepted until the block is back in idle.
// The pot product runs on a serial shift-add unit in parallel with the first divide.
// samples.ready is high only while idle; a finished result waits in the output
// register while the next item is accepted. A stalled result holds the block in steer.
// Reset clears the base duty, the state machine and the output valid.
module ir_wall_follow_duty_steer_unit
	import irwf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	irwf_in_if.sink   samples,
	irwf_out_if.source result
);

	state_t state_q, state_d;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                mul_start;
	logic                mul_busy;
	logic [DUTY_W-1:0]   mul_base;
	logic                in_fire;
	logic                load_out;

	logic                a_zero_q;
	logic                b_zero_q;
	logic [SAMPLE_W-1:0] sb_q;
	logic [DIST_W-1:0]   da_q;
	logic [DIST_W-1:0]   db_q;
	logic [DUTY_W-1:0]   base_q;

	logic                out_valid_q;
	logic [DUTY_W-1:0]   duty_a_q;
	logic [DUTY_W-1:0]   duty_b_q;
	logic [DIST_W-1:0]   dist_a_q;
	logic [DIST_W-1:0]   dist_b_q;
	logic [1:0]          led_q;

	logic                latch;
	logic                near;
	logic [DUTY_W-1:0]   duty_a;
	logic [DUTY_W-1:0]   duty_b;
	logic [1:0]          led;

	irwf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	irwf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.pot    (samples.pot_sample),
		.busy   (mul_busy),
		.base   (mul_base)
	);

	assign in_fire = samples.valid && samples.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (samples.valid) state_d = ST_DIV_A;
			ST_DIV_A: if (div_rsp.done) state_d = ST_DIV_B;
			ST_DIV_B: if (div_rsp.done) state_d = ST_STEER;
			ST_STEER: if (load_out) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready   = 1'b0;
		div_req.start   = 1'b0;
		div_req.divisor = samples.sample_a;
		mul_start       = 1'b0;
		load_out        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				div_req.start = samples.valid;
				mul_start     = samples.valid;
			end
			ST_DIV_A: begin
				div_req.start   = div_rsp.done;
				div_req.divisor = sb_q;
			end
			ST_STEER: begin
				load_out = !out_valid_q || result.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_zero_q <= samples.sample_a == '0;
			b_zero_q <= samples.sample_b == '0;
			sb_q     <= samples.sample_b;
		end
		if (state_q == ST_DIV_A && div_rsp.done) begin
			da_q <= a_zero_q ? DIST_NUM : div_rsp.quot;
		end
		if (state_q == ST_DIV_B && div_rsp.done) begin
			db_q <= b_zero_q ? DIST_NUM : div_rsp.quot;
		end
	end

	// steering rules, in priority order
	always_comb begin
		latch = base_q == '0;
		near  = (da_q <= NEAR_LIMIT) && (db_q <= NEAR_LIMIT);
		if (latch) begin
			duty_a = mul_base;
			duty_b = mul_base;
		end else if (near) begin
			if (da_q > db_q) begin
				duty_a = times_1000(da_q[NEAR_W-1:0]);
				duty_b = times_500(db_q[NEAR_W-1:0]);
			end else begin
				duty_a = times_500(da_q[NEAR_W-1:0]);
				duty_b = times_1000(db_q[NEAR_W-1:0]);
			end
		end else begin
			duty_a = (da_q > FAR_LIMIT) ? FAR_DUTY : times_500(da_q[NEAR_W-1:0]);
			duty_b = (db_q > FAR_LIMIT) ? FAR_DUTY : times_500(db_q[NEAR_W-1:0]);
		end

		if (duty_a > duty_b) begin
			led = LED_TOWARD_B;
		end else if (duty_b > duty_a) begin
			led = LED_TOWARD_A;
		end else if (duty_a == '0) begin
			led = LED_STOPPED;
		end else begin
			led = LED_FORWARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (latch) begin
					base_q <= mul_base;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			duty_a_q <= duty_a;
			duty_b_q <= duty_b;
			dist_a_q <= da_q;
			dist_b_q <= db_q;
			led_q    <= led;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.duty_a   = duty_a_q;
	assign result.duty_b   = duty_b_q;
	assign result.dist_a   = dist_a_q;
	assign result.dist_b   = dist_b_q;
	assign result.led_code = led_q;

`ifndef NO_ASSERTIONS
	a_mul_idle_at_steer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEER |-> !mul_busy)
		else $error("pot product not finished at steer");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_A || state_q == ST_DIV_B))
		else $error("divider finished outside a divide state");

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_DIV_A)
		else $error("accepted item did not start distance A");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (duty_a_q <= DUTY_FULL && duty_b_q <= DUTY_FULL))
		else $error("duty beyond full scale");

	a_led_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && led_q == LED_STOPPED) |-> (duty_a_q == '0 && duty_b_q == '0))
		else $error("stopped code with nonzero duty");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import irwf_pkg::*;

	localparam int POT_SPAN    = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_ITEMS  = 1800;
	localparam int QUIET_TAIL  = 300;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_LEN    = 400;
	localparam int DIR_N       = 19;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
		logic [DIST_W-1:0] dist_a;
		logic [DIST_W-1:0] dist_b;
		logic [1:0]        led_code;
	} steer_res_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sa;
		logic [SAMPLE_W-1:0] sb;
		logic [SAMPLE_W-1:0] pot;
		logic                typed;
		steer_res_t          want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	irwf_in_if  in_ch ();
	irwf_out_if res_ch ();

	ir_wall_follow_duty_steer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(in_ch),
		.result (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	steer_res_t        pending_steer [$];
	logic [DUTY_W-1:0] latched_base = '0;
	int                err_cnt      = 0;
	int                got_cnt      = 0;
	int                cycle_cnt    = 0;
	bit                quiet        = 1'b0;

	// typed rows first: reset latch with zero pot, first latch, the simple steering cases; then model rows
	dir_row_t dir_tab [DIR_N] = '{
		'{12'd0,    12'd0,    12'd0,    1'b1,
			'{16'd0, 16'd0, 15'd27500, 15'd27500, LED_STOPPED}},
		'{12'd4095, 12'd1,    12'd0,    1'b1,
			'{16'd0, 16'd0, 15'd6, 15'd27500, LED_STOPPED}},
		'{12'd4095, 12'd4095, 12'd4095, 1'b1,
			'{16'd39990, 16'd39990, 15'd6, 15'd6, LED_FORWARD}},
		'{12'd0,    12'd0,    12'd0,    1'b1,
			'{16'd20000, 16'd20000, 15'd27500, 15'd27500, LED_FORWARD}},
		'{12'd4095, 12'd4095, 12'd4095, 1'b1,
			'{16'd3000, 16'd6000, 15'd6, 15'd6, LED_TOWARD_A}},
		'{12'd1,    12'd4095, 12'd0,    1'b1,
			'{16'd20000, 16'd3000, 15'd27500, 15'd6, LED_TOWARD_B}},
		'{12'd1310,  12'd2750,  12'd0,    1'b0, '0},
		'{12'd1309,  12'd1310,  12'd0,    1'b0, '0},
		'{12'd339,   12'd340,   12'd4095, 1'b0, '0},
		'{12'd343,   12'd344,   12'd0,    1'b0, '0},
		'{12'd2,     12'd4094,  12'd0,    1'b0, '0},
		'{12'd1375,  12'd1375,  12'hAAA,  1'b0, '0},
		'{12'd2048,  12'd1366,  12'd0,    1'b0, '0},
		'{12'd687,   12'd687,   12'h555,  1'b0, '0},
		'{12'hAAA,   12'h555,   12'hFFF,  1'b0, '0},
		'{12'h555,   12'hAAA,   12'd0,    1'b0, '0},
		'{12'd3,     12'd1000,  12'd0,    1'b0, '0},
		'{12'd1000,  12'd3,     12'd0,    1'b0, '0},
		'{12'd4095,  12'd1309,  12'd0,    1'b0, '0}
	};

	function automatic steer_res_t predict_steer(input logic [SAMPLE_W-1:0] sa,
		input logic [SAMPLE_W-1:0] sb, input logic [SAMPLE_W-1:0] pot);
		steer_res_t  r;
		int unsigned da, db, ya, yb, pu;
		da = (sa == 0) ? int'(DIST_NUM) : int'(DIST_NUM) / int'(sa);
		db = (sb == 0) ? int'(DIST_NUM) : int'(DIST_NUM) / int'(sb);
		pu = pot;
		if (latched_base == 0) begin
			latched_base = DUTY_W'((int'(DUTY_FULL) * pu) / POT_SPAN);
			ya = latched_base;
			yb = latched_base;
		end else if (da <= NEAR_LIMIT && db <= NEAR_LIMIT) begin
			// wider side doubles; a tie favors B
			if (da > db) begin
				ya = da * (int'(DUTY_FULL) / 40);
				yb = db * (int'(DUTY_FULL) / int'(FAR_LIMIT));
			end else begin
				ya = da * (int'(DUTY_FULL) / int'(FAR_LIMIT));
				yb = db * (int'(DUTY_FULL) / 40);
			end
		end else begin
			ya = (da > FAR_LIMIT) ? int'(FAR_DUTY) : da * (int'(DUTY_FULL) / int'(FAR_LIMIT));
			yb = (db > FAR_LIMIT) ? int'(FAR_DUTY) : db * (int'(DUTY_FULL) / int'(FAR_LIMIT));
		end
		r.duty_a = ya[DUTY_W-1:0];
		r.duty_b = yb[DUTY_W-1:0];
		r.dist_a = da[DIST_W-1:0];
		r.dist_b = db[DIST_W-1:0];
		if (ya > yb)
			r.led_code = LED_TOWARD_B;
		else if (yb > ya)
			r.led_code = LED_TOWARD_A;
		else if (ya == 0)
			r.led_code = LED_STOPPED;
		else
			r.led_code = LED_FORWARD;
		return r;
	endfunction

	// 0: far (d > 80 or zero), 1: edges, 2: middle band, 3: near (d <= 20), else anything
	function automatic logic [SAMPLE_W-1:0] pick_sample(input int region);
		case (region)
			0: return SAMPLE_W'($urandom_range(0, 339));
			1: begin
				case ($urandom_range(0, 7))
					0: return 12'd0;
					1: return 12'd1;
					2: return 12'd339;
					3: return 12'd340;
					4: return 12'd343;
					5: return 12'd1309;
					6: return 12'd1310;
					default: return 12'd4095;
				endcase
			end
			2: return SAMPLE_W'($urandom_range(340, 1309));
			3: return SAMPLE_W'($urandom_range(1310, 4095));
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic send_samples(input logic [SAMPLE_W-1:0] sa,
		input logic [SAMPLE_W-1:0] sb, input logic [SAMPLE_W-1:0] pot,
		input logic typed, input steer_res_t want);
		steer_res_t model;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.sample_a   <= sa;
		in_ch.sample_b   <= sb;
		in_ch.pot_sample <= pot;
		do @(posedge clk); while (!in_ch.ready);
		// model runs on every transfer so the latch state tracks the typed rows too
		model = predict_steer(sa, sb, pot);
		pending_steer.push_back(typed ? want : model);
	endtask

	initial begin
		logic [SAMPLE_W-1:0] sa, sb, pot;
		int                  mode;
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.sample_a   = '0;
		in_ch.sample_b   = '0;
		in_ch.pot_sample = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_N; i++)
			send_samples(dir_tab[i].sa, dir_tab[i].sb, dir_tab[i].pot,
				dir_tab[i].typed, dir_tab[i].want);
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i >= RAND_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			mode = $urandom_range(0, 9);
			if (mode < 4) begin
				sa = pick_sample(3);
				sb = ($urandom_range(0, 3) == 0) ? sa : pick_sample(3);
			end else if (mode < 9) begin
				sa = pick_sample($urandom_range(0, 4));
				sb = pick_sample($urandom_range(0, 4));
			end else begin
				sa = SAMPLE_W'($urandom);
				sb = SAMPLE_W'($urandom);
			end
			pot = SAMPLE_W'($urandom_range(0, 4095));
			send_samples(sa, sb, pot, 1'b0, '0);
		end
		in_ch.valid <= 1'b0;
		while (pending_steer.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side: checks transfers, random stall bursts, one long hold-off
	initial begin
		steer_res_t got, want;
		int         stall_cnt;
		int         hold_cnt;
		bit         hold_done;
		stall_cnt    = 0;
		hold_cnt     = 0;
		hold_done    = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.duty_a, res_ch.duty_b, res_ch.dist_a, res_ch.dist_b,
					res_ch.led_code};
				got_cnt++;
				if (pending_steer.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result transfer #%0d", got_cnt);
				end else begin
					want = pending_steer.pop_front();
					if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
						got.dist_a !== want.dist_a || got.dist_b !== want.dist_b ||
						got.led_code !== want.led_code) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("result #%0d mismatch: exp duty %0d/%0d dist %0d/%0d led %0d",
								got_cnt, want.duty_a, want.duty_b, want.dist_a,
								want.dist_b, want.led_code);
							$display("  got duty %0d/%0d dist %0d/%0d led %0d",
								got.duty_a, got.duty_b, got.dist_a, got.dist_b,
								got.led_code);
						end
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				res_ch.ready <= 1'b0;
			end else if (!hold_done && got_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_cnt  = HOLD_LEN - 1;
				res_ch.ready <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_cnt = $urandom_range(1, 6) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule
